@@ sv/abpu_pkg.sv @@
// Shared types, widths and constant tables for the Adams-Bashforth position update unit.
`timescale 1ns / 1ps
`default_nettype none

package abpu_pkg;

  // Coordinate format: signed, shared by positions and velocities
  localparam int COORD_W = 32;
  localparam int CNT_W   = 3;
  localparam int DT_W    = 32;
  localparam int DT_HALF = DT_W / 2;

  // Weighted velocity sum: largest coefficient magnitude sum is 160 (< 2^8)
  localparam int COEF_W  = 8;
  localparam int TERM_W  = COORD_W + COEF_W;
  localparam int SUM_W   = COORD_W + COEF_W;

  // Time-step product, split into two half-width partial products
  localparam int PART_W  = SUM_W + DT_HALF + 1;
  localparam int PROD_W  = SUM_W + DT_W + 1;
  localparam int SHIFT   = DT_W - 1;
  localparam int V_W     = PROD_W - SHIFT;

  // Divide-by-three of the biased value, done as two chunks
  localparam int U_W     = V_W + 1;
  localparam int LO_W    = U_W / 2;
  localparam int HI_W    = U_W - LO_W;
  localparam int N2_W    = LO_W + 2;
  localparam int RES_W   = V_W + 1;
  localparam int DEN_VAL_W = 5;

  localparam logic [31:0] DIV3_MAGIC = 32'hAAAA_AAAB;
  localparam logic [U_W-1:0] DIV3_BIAS = U_W'(3) << (V_W - 1);
  localparam logic [U_W-1:0] DIV3_QOFF = U_W'(1) << (V_W - 1);

  localparam logic signed [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] POS_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // History counts that select the integration rule
  localparam logic [CNT_W-1:0] CNT_EULER = 3'd1;
  localparam logic [CNT_W-1:0] CNT_AB2   = 3'd2;
  localparam logic [CNT_W-1:0] CNT_AB3   = 3'd3;
  localparam logic [CNT_W-1:0] CNT_AB4   = 3'd4;

  typedef enum logic [1:0] {
    DEN_1,
    DEN_2,
    DEN_12,
    DEN_24
  } den_t;

  // Item after the weighted sum
  typedef struct packed {
    logic [COORD_W-1:0] pos;
    logic [SUM_W-1:0]   sum;
    den_t               den;
  } abpu_sum_t;

  // Item after time-step scaling: floor(sum * dt / 2^31) + den
  typedef struct packed {
    logic [COORD_W-1:0] pos;
    logic [V_W-1:0]     val;
    den_t               den;
  } abpu_scaled_t;

  // Item carrying the rounded increment
  typedef struct packed {
    logic [COORD_W-1:0] pos;
    logic [V_W-1:0]     inc;
  } abpu_inc_t;

  // Coefficient of one velocity lane for a history count
  function automatic logic signed [COEF_W-1:0] ab_coef(input logic [CNT_W-1:0] cnt,
                                                       input logic [1:0] lane);
    logic signed [COEF_W-1:0] c;
    c = '0;
    unique case (cnt)
      CNT_AB4: begin
        unique case (lane)
          2'd0:    c = COEF_W'(55);
          2'd1:    c = COEF_W'(-59);
          2'd2:    c = COEF_W'(37);
          default: c = COEF_W'(-9);
        endcase
      end
      CNT_AB3: begin
        unique case (lane)
          2'd0:    c = COEF_W'(23);
          2'd1:    c = COEF_W'(-16);
          2'd2:    c = COEF_W'(5);
          default: c = '0;
        endcase
      end
      CNT_AB2: begin
        unique case (lane)
          2'd0:    c = COEF_W'(3);
          2'd1:    c = COEF_W'(-1);
          default: c = '0;
        endcase
      end
      CNT_EULER: c = (lane == 2'd0) ? COEF_W'(1) : '0;
      default:   c = '0;
    endcase
    return c;
  endfunction

  // Denominator code for a history count; Euler and the no-update counts use the unit denominator
  function automatic den_t ab_den(input logic [CNT_W-1:0] cnt);
    den_t d;
    unique case (cnt)
      CNT_AB4: d = DEN_24;
      CNT_AB3: d = DEN_12;
      CNT_AB2: d = DEN_2;
      default: d = DEN_1;
    endcase
    return d;
  endfunction

  function automatic logic [DEN_VAL_W-1:0] den_value(input den_t d);
    logic [DEN_VAL_W-1:0] v;
    unique case (d)
      DEN_1:   v = 5'd1;
      DEN_2:   v = 5'd2;
      DEN_12:  v = 5'd12;
      default: v = 5'd24;
    endcase
    return v;
  endfunction

  // Exact floor(n / 3) for any 32-bit n by reciprocal multiply
  function automatic logic [31:0] div3(input logic [31:0] n);
    logic [63:0] p;
    p = 64'(n) * 64'(DIV3_MAGIC);
    return {1'b0, p[63:33]};
  endfunction

endpackage

`default_nettype wire

@@ sv/abpu_wsum.sv @@
// Coefficient lanes and weighted velocity sum, two pipeline stages.
`timescale 1ns / 1ps
`default_nettype none

module abpu_wsum (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 up_valid,
  output logic                                 up_ready,
  input  logic signed [abpu_pkg::COORD_W-1:0]  pos,
  input  logic signed [abpu_pkg::COORD_W-1:0]  v0,
  input  logic signed [abpu_pkg::COORD_W-1:0]  v1,
  input  logic signed [abpu_pkg::COORD_W-1:0]  v2,
  input  logic signed [abpu_pkg::COORD_W-1:0]  v3,
  input  logic        [abpu_pkg::CNT_W-1:0]    count,
  output logic                                 dn_valid,
  input  logic                                 dn_ready,
  output abpu_pkg::abpu_sum_t                  dn_item
);
  import abpu_pkg::*;

  logic                      s1_valid_r;
  logic                      s1_ready;
  logic signed [COORD_W-1:0] s1_pos_r;
  logic signed [TERM_W-1:0]  s1_term_r [4];
  logic signed [TERM_W-1:0]  term_nxt  [4];
  den_t                      s1_den_r;

  logic                      s2_valid_r;
  logic                      s2_ready;
  abpu_sum_t                 s2_item_r;
  abpu_sum_t                 s2_item_nxt;
  logic signed [SUM_W-1:0]   sum_nxt;

  assign s2_ready = !s2_valid_r || dn_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign up_ready = s1_ready;

  // Scale each velocity lane by its coefficient
  always_comb begin
    term_nxt[0] = TERM_W'(v0) * TERM_W'(ab_coef(count, 2'd0));
    term_nxt[1] = TERM_W'(v1) * TERM_W'(ab_coef(count, 2'd1));
    term_nxt[2] = TERM_W'(v2) * TERM_W'(ab_coef(count, 2'd2));
    term_nxt[3] = TERM_W'(v3) * TERM_W'(ab_coef(count, 2'd3));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_pos_r     <= pos;
      s1_term_r[0] <= term_nxt[0];
      s1_term_r[1] <= term_nxt[1];
      s1_term_r[2] <= term_nxt[2];
      s1_term_r[3] <= term_nxt[3];
      s1_den_r     <= ab_den(count);
    end
  end

  // Add the four lanes
  always_comb begin
    sum_nxt = s1_term_r[0] + s1_term_r[1] + s1_term_r[2] + s1_term_r[3];
    s2_item_nxt.pos = s1_pos_r;
    s2_item_nxt.sum = sum_nxt;
    s2_item_nxt.den = s1_den_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_item_r <= s2_item_nxt;
    end
  end

  assign dn_valid = s2_valid_r;
  assign dn_item  = s2_item_r;

endmodule

`default_nettype wire

@@ sv/abpu_scale.sv @@
// Time-step multiply as two partial products, then recombine and add the rounding bias.
`timescale 1ns / 1ps
`default_nettype none

module abpu_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [abpu_pkg::DT_W-1:0]     time_step,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  abpu_pkg::abpu_sum_t           up_item,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output abpu_pkg::abpu_scaled_t        dn_item
);
  import abpu_pkg::*;

  logic signed [SUM_W-1:0]   sum_in;
  logic signed [DT_HALF:0]   dt_hi;
  logic signed [DT_HALF:0]   dt_lo;
  logic signed [PART_W-1:0]  x_nxt;
  logic signed [PART_W-1:0]  y_nxt;

  logic                      s3_valid_r;
  logic                      s3_ready;
  logic [COORD_W-1:0]        s3_pos_r;
  logic signed [PART_W-1:0]  s3_x_r;
  logic signed [PART_W-1:0]  s3_y_r;
  den_t                      s3_den_r;

  logic signed [PROD_W-1:0]  x_ext;
  logic signed [PROD_W-1:0]  y_ext;
  logic signed [PROD_W-1:0]  den_ext;
  logic signed [PROD_W-1:0]  prod;
  abpu_scaled_t              s4_item_nxt;
  abpu_scaled_t              s4_item_r;
  logic                      s4_valid_r;
  logic                      s4_ready;

  assign s4_ready = !s4_valid_r || dn_ready;
  assign s3_ready = !s3_valid_r || s4_ready;
  assign up_ready = s3_ready;

  // Partial products against the upper and lower halves of the time step
  always_comb begin
    sum_in = up_item.sum;
    dt_hi  = {1'b0, time_step[DT_W-1:DT_HALF]};
    dt_lo  = {1'b0, time_step[DT_HALF-1:0]};
    x_nxt  = PART_W'(sum_in) * PART_W'(dt_hi);
    y_nxt  = PART_W'(sum_in) * PART_W'(dt_lo);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_pos_r <= up_item.pos;
      s3_x_r   <= x_nxt;
      s3_y_r   <= y_nxt;
      s3_den_r <= up_item.den;
    end
  end

  // Recombine; adding den at the binary point gives floor(s*dt/2^31) + den
  always_comb begin
    x_ext   = PROD_W'(s3_x_r);
    y_ext   = PROD_W'(s3_y_r);
    den_ext = PROD_W'(den_value(s3_den_r));
    prod    = (x_ext <<< DT_HALF) + y_ext + (den_ext <<< SHIFT);
    s4_item_nxt.pos = s3_pos_r;
    s4_item_nxt.val = prod[PROD_W-1:SHIFT];
    s4_item_nxt.den = s3_den_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (s4_ready) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready) begin
      s4_item_r <= s4_item_nxt;
    end
  end

  assign dn_valid = s4_valid_r;
  assign dn_item  = s4_item_r;

endmodule

`default_nettype wire

@@ sv/abpu_div.sv @@
// Floor division by twice the denominator: shifts, and a two-chunk divide by three.
`timescale 1ns / 1ps
`default_nettype none

module abpu_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  abpu_pkg::abpu_scaled_t        up_item,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output abpu_pkg::abpu_inc_t           dn_item
);
  import abpu_pkg::*;

  logic signed [V_W-1:0]  val_in;
  logic signed [V_W-1:0]  direct_nxt;
  logic signed [V_W-1:0]  w_nxt;
  logic                   mode_nxt;
  logic [U_W-1:0]         u_nxt;
  logic [HI_W-1:0]        hi_nxt;
  logic [HI_W-1:0]        qh_nxt;
  logic [HI_W-1:0]        rem_nxt;

  logic                   s5_valid_r;
  logic                   s5_ready;
  logic [COORD_W-1:0]     s5_pos_r;
  logic                   s5_mode_r;
  logic [V_W-1:0]         s5_direct_r;
  logic [HI_W-1:0]        s5_qh_r;
  logic [1:0]             s5_rh_r;
  logic [LO_W-1:0]        s5_lo_r;

  logic [N2_W-1:0]        n2;
  logic [LO_W-1:0]        ql;
  logic [U_W-1:0]         q_full;
  logic [U_W-1:0]         q_unbiased;
  abpu_inc_t              s6_item_nxt;
  abpu_inc_t              s6_item_r;
  logic                   s6_valid_r;
  logic                   s6_ready;

  assign s6_ready = !s6_valid_r || dn_ready;
  assign s5_ready = !s5_valid_r || s6_ready;
  assign up_ready = s5_ready;

  // Pick shift path or divide-by-three path; bias the latter to be nonnegative
  always_comb begin
    val_in     = up_item.val;
    direct_nxt = val_in >>> 1;
    w_nxt      = val_in >>> 3;
    mode_nxt   = 1'b0;
    unique case (up_item.den)
      DEN_1:   direct_nxt = val_in >>> 1;
      DEN_2:   direct_nxt = val_in >>> 2;
      DEN_12: begin
        w_nxt    = val_in >>> 3;
        mode_nxt = 1'b1;
      end
      default: begin
        w_nxt    = val_in >>> 4;
        mode_nxt = 1'b1;
      end
    endcase
    u_nxt   = U_W'(w_nxt) + DIV3_BIAS;
    hi_nxt  = u_nxt[U_W-1:LO_W];
    qh_nxt  = HI_W'(div3(32'(hi_nxt)));
    rem_nxt = hi_nxt - (qh_nxt << 1) - qh_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (s5_ready) begin
      s5_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_ready) begin
      s5_pos_r    <= up_item.pos;
      s5_mode_r   <= mode_nxt;
      s5_direct_r <= direct_nxt;
      s5_qh_r     <= qh_nxt;
      s5_rh_r     <= rem_nxt[1:0];
      s5_lo_r     <= u_nxt[LO_W-1:0];
    end
  end

  // Divide the low chunk with the carried remainder, then drop the bias
  always_comb begin
    n2         = {s5_rh_r, s5_lo_r};
    ql         = LO_W'(div3(32'(n2)));
    q_full     = {s5_qh_r, ql};
    q_unbiased = q_full - DIV3_QOFF;
    s6_item_nxt.pos = s5_pos_r;
    s6_item_nxt.inc = s5_mode_r ? q_unbiased[V_W-1:0] : s5_direct_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r <= 1'b0;
    end else if (s6_ready) begin
      s6_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s6_ready) begin
      s6_item_r <= s6_item_nxt;
    end
  end

  assign dn_valid = s6_valid_r;
  assign dn_item  = s6_item_r;

`ifndef NO_ASSERTIONS
  // The high-chunk remainder must be a true remainder of division by three
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (s5_valid_r && s5_mode_r) |-> (s5_rh_r != 2'd3))
    else $error("divide-by-three remainder out of range");
`endif

endmodule

`default_nettype wire

@@ sv/adams_bashforth_position_update_unit.sv @@
// Top level of the Adams-Bashforth position update unit: step register, pipeline, output stage.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+-------------------------------------------
//   in_      | input     | in_valid/in_ready   | position, four velocities, history count
//   out_     | output    | out_valid/out_ready | new_position, saturated flag
//   cfg_     | input     | cfg_wr_en only      | cfg_wr_data: time step, unsigned Q0.32
//
// One item per cycle sustained while out_ready stays high; each item passes through
// the seven register stages (lanes, sum, partial products, recombine,
// high divide chunk, low divide chunk, add and saturate).
// Reset is synchronous on rst_n: it clears every stage valid bit and the time step.
// Each stage holds its item while the next is full and stalled; empty stages
// keep filling, so no item is dropped or repeated under backpressure.
`timescale 1ns / 1ps
`default_nettype none

module adams_bashforth_position_update_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic        [abpu_pkg::DT_W-1:0]     cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [abpu_pkg::COORD_W-1:0]  in_position,
  input  logic signed [abpu_pkg::COORD_W-1:0]  in_vel_now,
  input  logic signed [abpu_pkg::COORD_W-1:0]  in_vel_back_one,
  input  logic signed [abpu_pkg::COORD_W-1:0]  in_vel_back_two,
  input  logic signed [abpu_pkg::COORD_W-1:0]  in_vel_back_three,
  input  logic        [abpu_pkg::CNT_W-1:0]    in_history_count,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [abpu_pkg::COORD_W-1:0]  out_new_position,
  output logic                                 out_saturated
);
  import abpu_pkg::*;

  logic [DT_W-1:0]           time_step_r;

  logic                      sum_valid;
  logic                      sum_ready;
  abpu_sum_t                 sum_item;
  logic                      scl_valid;
  logic                      scl_ready;
  abpu_scaled_t              scl_item;
  logic                      inc_valid;
  logic                      inc_ready;
  abpu_inc_t                 inc_item;

  logic signed [COORD_W-1:0] pos_in;
  logic signed [V_W-1:0]     inc_in;
  logic signed [RES_W-1:0]   res_full;
  logic signed [COORD_W-1:0] res_nxt;
  logic                      sat_nxt;

  logic                      s7_valid_r;
  logic                      s7_ready;
  logic signed [COORD_W-1:0] s7_pos_r;
  logic                      s7_sat_r;

  // Hold the time step; the user must write it only while the pipeline is idle (not enforced here)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= '0;
    end else if (cfg_wr_en) begin
      time_step_r <= cfg_wr_data;
    end
  end

  abpu_wsum u_wsum (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .pos      (in_position),
    .v0       (in_vel_now),
    .v1       (in_vel_back_one),
    .v2       (in_vel_back_two),
    .v3       (in_vel_back_three),
    .count    (in_history_count),
    .dn_valid (sum_valid),
    .dn_ready (sum_ready),
    .dn_item  (sum_item)
  );

  abpu_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .time_step (time_step_r),
    .up_valid  (sum_valid),
    .up_ready  (sum_ready),
    .up_item   (sum_item),
    .dn_valid  (scl_valid),
    .dn_ready  (scl_ready),
    .dn_item   (scl_item)
  );

  abpu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (scl_valid),
    .up_ready (scl_ready),
    .up_item  (scl_item),
    .dn_valid (inc_valid),
    .dn_ready (inc_ready),
    .dn_item  (inc_item)
  );

  assign s7_ready  = !s7_valid_r || out_ready;
  assign inc_ready = s7_ready;

  // Add the increment and clip to the coordinate range
  always_comb begin
    pos_in   = inc_item.pos;
    inc_in   = inc_item.inc;
    res_full = RES_W'(pos_in) + RES_W'(inc_in);
    res_nxt  = res_full[COORD_W-1:0];
    sat_nxt  = 1'b0;
    if (res_full > RES_W'(POS_MAX)) begin
      res_nxt = POS_MAX;
      sat_nxt = 1'b1;
    end else if (res_full < RES_W'(POS_MIN)) begin
      res_nxt = POS_MIN;
      sat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_valid_r <= 1'b0;
    end else if (s7_ready) begin
      s7_valid_r <= inc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s7_ready) begin
      s7_pos_r <= res_nxt;
      s7_sat_r <= sat_nxt;
    end
  end

  assign out_valid        = s7_valid_r;
  assign out_new_position = s7_pos_r;
  assign out_saturated    = s7_sat_r;

`ifndef NO_ASSERTIONS
  // A clipped result sits exactly on a range limit
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_new_position == POS_MAX || out_new_position == POS_MIN))
    else $error("saturated result not at a range limit");

  // With the output stage empty, every stage can advance, so input is open
  a_ready_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while output stage is empty");

  // Reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

`default_nettype wire

@@ tb/sv/adams_bashforth_position_update_unit_tb.sv @@
// Self-checking testbench for the Adams-Bashforth position update unit.
`timescale 1ns / 1ps

module adams_bashforth_position_update_unit_tb;
  import abpu_pkg::*;

  localparam logic [CNT_W-1:0] CNT_NONE = 3'd0;
  localparam int HOLD_AT_FIRST = 200;
  localparam int HOLD_AT_SECOND = 450;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_PER_PHASE = 105;

  typedef struct {
    logic signed [COORD_W-1:0] pos;
    logic signed [COORD_W-1:0] v0;
    logic signed [COORD_W-1:0] v1;
    logic signed [COORD_W-1:0] v2;
    logic signed [COORD_W-1:0] v3;
    logic [CNT_W-1:0] cnt;
  } coord_item_t;

  typedef struct {
    logic signed [COORD_W-1:0] new_pos;
    logic clipped;
  } coord_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [DT_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_W-1:0] in_position = '0;
  logic signed [COORD_W-1:0] in_vel_now = '0;
  logic signed [COORD_W-1:0] in_vel_back_one = '0;
  logic signed [COORD_W-1:0] in_vel_back_two = '0;
  logic signed [COORD_W-1:0] in_vel_back_three = '0;
  logic [CNT_W-1:0] in_history_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [COORD_W-1:0] out_new_position;
  logic out_saturated;

  // Stimulus and expectation stores
  coord_item_t coords_to_send[$];
  coord_result_t predicted_positions[$];
  coord_item_t on_bus;
  coord_result_t oldest_pred;
  logic [DT_W-1:0] step_now = '0;

  // Idle control, bookkeeping
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  int items_taken = 0;
  int results_seen = 0;
  int clipped_seen = 0;
  int err_count = 0;
  int step_settings = 1;
  int leftover = 0;
  int count_hits[8];
  logic took;

  adams_bashforth_position_update_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_position       (in_position),
    .in_vel_now        (in_vel_now),
    .in_vel_back_one   (in_vel_back_one),
    .in_vel_back_two   (in_vel_back_two),
    .in_vel_back_three (in_vel_back_three),
    .in_history_count  (in_history_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_new_position  (out_new_position),
    .out_saturated     (out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Advance one coordinate: weighted velocity sum, scale by dt/(den*2^32),
  // round half up, add to the position and clip to the coordinate range
  function automatic coord_result_t advance_coord(input coord_item_t it,
                                                  input logic [DT_W-1:0] dt);
    logic signed [47:0] w0, w1, w2, w3, wsum;
    logic signed [95:0] s_wide, dt_wide, prod, num, m, q, total, hi, lo;
    int den;
    coord_result_t r;
    w0 = it.v0;
    w1 = it.v1;
    w2 = it.v2;
    w3 = it.v3;
    den = 0;
    wsum = '0;
    case (it.cnt)
      CNT_AB4: begin
        wsum = 55 * w0 - 59 * w1 + 37 * w2 - 9 * w3;
        den = 24;
      end
      CNT_AB3: begin
        wsum = 23 * w0 - 16 * w1 + 5 * w2;
        den = 12;
      end
      CNT_AB2: begin
        wsum = 3 * w0 - w1;
        den = 2;
      end
      CNT_EULER: begin
        wsum = w0;
        den = 1;
      end
      default: den = 0;
    endcase
    r.new_pos = it.pos;
    r.clipped = 1'b0;
    if (den != 0) begin
      s_wide = wsum;
      dt_wide = {64'd0, dt};
      prod = s_wide * dt_wide;
      // floor(sum * dt / 2^31), then floor((a + den) / (2 * den))
      num = (prod >>> 31) + den;
      m = 2 * den;
      q = num / m;
      if (num < 0 && (num % m) != 0) begin
        q = q - 1;
      end
      total = it.pos;
      total = total + q;
      hi = POS_MAX;
      lo = POS_MIN;
      if (total > hi) begin
        r.new_pos = POS_MAX;
        r.clipped = 1'b1;
      end else if (total < lo) begin
        r.new_pos = POS_MIN;
        r.clipped = 1'b1;
      end else begin
        r.new_pos = total[COORD_W-1:0];
      end
    end
    return r;
  endfunction

  // Mix of full-range, near-unit, mid-range and boundary values
  function automatic logic signed [COORD_W-1:0] pick_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(5))
      0, 1: return r;
      2: return {{15{r[16]}}, r[16:0]};
      3: return {{7{r[24]}}, r[24:0]};
      4: begin
        case ($urandom_range(4))
          0: return POS_MAX;
          1: return POS_MIN;
          2: return '0;
          3: return '1;
          default: return 32'sd1;
        endcase
      end
      default: return {{11{r[20]}}, r[20:0]};
    endcase
  endfunction

  task automatic log_failure(input string msg);
    if (err_count < 10) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    err_count++;
  endtask

  task automatic add_item(input logic signed [COORD_W-1:0] pos,
                          input logic signed [COORD_W-1:0] v0,
                          input logic signed [COORD_W-1:0] v1,
                          input logic signed [COORD_W-1:0] v2,
                          input logic signed [COORD_W-1:0] v3,
                          input logic [CNT_W-1:0] cnt);
    coord_item_t it;
    it.pos = pos;
    it.v0 = v0;
    it.v1 = v1;
    it.v2 = v2;
    it.v3 = v3;
    it.cnt = cnt;
    coords_to_send.push_back(it);
  endtask

  function automatic logic [CNT_W-1:0] CNT_CNT(input logic [CNT_W-1:0] base, input int off);
    return base + CNT_W'(off);
  endfunction

  task automatic add_random_items(input int n);
    logic [CNT_W-1:0] cnt;
    for (int i = 0; i < n; i++) begin
      // mostly real updates, some no-update counts including the unused codes
      if ($urandom_range(99) < 85) begin
        cnt = CNT_CNT(CNT_EULER, $urandom_range(3));
      end else begin
        cnt = ($urandom_range(3) == 0) ? CNT_NONE : CNT_CNT(CNT_AB4, $urandom_range(3, 1));
      end
      add_item(pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(), cnt);
    end
  endtask

  // Sample at the falling edge so every update of the rising edge has landed
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (coords_to_send.size() != 0 || in_valid || predicted_positions.size() != 0);
  endtask

  task automatic write_step(input logic [DT_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    step_now = v;
    step_settings++;
  endtask

  task automatic run_phase(input logic [DT_W-1:0] dt, input int n, input int s_pct,
                           input int r_pct);
    write_step(dt);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    add_random_items(n);
    wait_idle();
  endtask

  // Driver: offer the next pending item, hold it until taken, idle in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_positions.push_back(advance_coord(on_bus, step_now));
        count_hits[on_bus.cnt]++;
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (coords_to_send.size() != 0) begin
          on_bus = coords_to_send.pop_front();
          in_position <= on_bus.pos;
          in_vel_now <= on_bus.v0;
          in_vel_back_one <= on_bus.v1;
          in_vel_back_two <= on_bus.v2;
          in_vel_back_three <= on_bus.v3;
          in_history_count <= on_bus.cnt;
          in_valid <= 1'b1;
          if ($urandom_range(99) < send_idle_pct) begin
            send_gap <= $urandom_range(14, 1);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest prediction, drive ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap <= 0;
      hold_left <= 0;
    end else begin
      took = out_valid && out_ready;
      if (took) begin
        results_seen++;
        if (out_saturated === 1'b1) begin
          clipped_seen++;
        end
        if (predicted_positions.size() == 0) begin
          log_failure($sformatf("result %0d (new_position %0d) with nothing expected",
                                results_seen, out_new_position));
        end else begin
          oldest_pred = predicted_positions.pop_front();
          if (out_new_position !== oldest_pred.new_pos ||
              out_saturated !== oldest_pred.clipped) begin
            log_failure($sformatf(
              "result %0d: new_position exp %0d got %0d, saturated exp %0b got %0b",
              results_seen, oldest_pred.new_pos, out_new_position,
              oldest_pred.clipped, out_saturated));
          end
        end
      end
      // Long hold-off so the pipeline fills and stalls its input
      if (took && (results_seen == HOLD_AT_FIRST || results_seen == HOLD_AT_SECOND)) begin
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if ($urandom_range(99) < recv_idle_pct) begin
        recv_gap <= $urandom_range(13, 0);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus sequence
  initial begin
    for (int i = 0; i < 8; i++) begin
      count_hits[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero time step out of reset: positions pass through
    send_idle_pct = 30;
    recv_idle_pct = 30;
    add_item(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, CNT_AB4);
    add_item(POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, CNT_EULER);
    add_item('1, 32'sd1, POS_MIN, '0, '0, CNT_AB2);
    wait_idle();

    // Half step: rounding ties, every count, ignored history
    write_step(32'h8000_0000);
    add_item('0, 32'sd1, '0, '0, '0, CNT_EULER);
    add_item('0, '1, '0, '0, '0, CNT_EULER);
    add_item('0, 32'sd3, '0, '0, '0, CNT_EULER);
    add_item('0, -32'sd3, '0, '0, '0, CNT_EULER);
    add_item(32'sd12345, POS_MAX, POS_MIN, POS_MAX, POS_MIN, CNT_NONE);
    add_item(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, CNT_AB4 + 3'd1);
    add_item(POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, CNT_AB4 + 3'd2);
    add_item(32'sd7, 32'sd65536, '1, '0, POS_MAX, CNT_AB4 + 3'd3);
    add_item(32'sd100, 32'sd65536, 32'sd131072, POS_MIN, POS_MAX, CNT_AB2);
    add_item(-32'sd100, 32'sd65536, -32'sd131072, 32'sd196608, POS_MIN, CNT_AB3);
    add_item(32'sd5, -32'sd65536, 32'sd32768, -32'sd16384, 32'sd8192, CNT_AB4);
    wait_idle();

    // Full step: clip at both ends for Euler and AB4, at the top for AB2, at the bottom for AB3
    write_step('1);
    add_item(POS_MAX, POS_MAX, '0, '0, '0, CNT_EULER);
    add_item(POS_MIN, POS_MIN, '0, '0, '0, CNT_EULER);
    add_item('0, POS_MAX, POS_MIN, POS_MAX, POS_MIN, CNT_AB4);
    add_item('0, POS_MIN, POS_MAX, POS_MIN, POS_MAX, CNT_AB4);
    add_item('0, POS_MIN, POS_MAX, POS_MIN, '0, CNT_AB3);
    add_item('0, POS_MAX, POS_MIN, '0, '0, CNT_AB2);
    add_item(POS_MAX, '1, '0, '0, '0, CNT_EULER);
    wait_idle();

    // Random phases over several steps; the last runs with no idling
    run_phase(32'd1, RANDOM_PER_PHASE, 25, 25);
    run_phase($urandom, RANDOM_PER_PHASE, 0, 40);
    run_phase(32'h0001_0000, RANDOM_PER_PHASE, 40, 0);
    run_phase($urandom, RANDOM_PER_PHASE, 20, 20);
    run_phase('0, RANDOM_PER_PHASE, 35, 35);
    run_phase($urandom, RANDOM_PER_PHASE, 0, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    leftover = predicted_positions.size();
    if (leftover != 0) begin
      log_failure($sformatf("%0d predicted results never arrived", leftover));
    end
    $display("Run covered %0d items and %0d results over %0d time-step settings, %0d clipped.",
             items_taken, results_seen, step_settings, clipped_seen);
    $display("History counts 0..7 seen %0d %0d %0d %0d %0d %0d %0d %0d times; %0d errors.",
             count_hits[0], count_hits[1], count_hits[2], count_hits[3],
             count_hits[4], count_hits[5], count_hits[6], count_hits[7], err_count);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #6_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
